// File: hdl/tatan_pkg.sv
// Shared types, constants and the arctangent table for the table-based atan2 core
`timescale 1ns / 1ps

package tatan_pkg;

    // Internal magnitude width: a coordinate of -32768 folds to 32768
    localparam int MAG_W     = 17;
    localparam int ANGLE_W   = 16;
    localparam int IDX_W     = 8;
    localparam int REM_W     = IDX_W - 1;
    localparam int DIV_STEPS = IDX_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int PART_SHIFT = 5;

    // Correction words applied by the octant fold, and the table part for equal magnitudes
    localparam logic [ANGLE_W-1:0] CORR_QUARTER = 16'h4000;
    localparam logic [ANGLE_W-1:0] CORR_HALF    = 16'h8000;
    localparam logic [ANGLE_W-1:0] CORR_MIRROR  = 16'h3fff;
    localparam logic [ANGLE_W-1:0] PART_DIAG    = 16'h2000;

    // Operations of the shared shift / subtract unit
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SHIFT,
        OP_DIV_INIT,
        OP_DIV_STEP
    } unit_op_t;

    // Status returned by the unit to the sequencer
    typedef struct packed {
        logic                 normed;
        logic                 hi_zero;
        logic                 lo_eq_hi;
        logic [IDX_W-1:0]     quot;
        logic [ANGLE_W-1:0]   corr;
    } unit_status_t;

    // round(1024 * atan(i / 256) / pi)
    localparam logic [7:0] ATAN_TAB [0:255] = '{
        8'd0,8'd1,8'd3,8'd4,8'd5,8'd6,8'd8,8'd9,8'd10,8'd11,8'd13,8'd14,8'd15,8'd17,8'd18,8'd19,
        8'd20,8'd22,8'd23,8'd24,8'd25,8'd27,8'd28,8'd29,8'd30,8'd32,8'd33,8'd34,8'd36,8'd37,8'd38,
        8'd39,
        8'd41,8'd42,8'd43,8'd44,8'd46,8'd47,8'd48,8'd49,8'd51,8'd52,8'd53,8'd54,8'd55,8'd57,8'd58,
        8'd59,8'd60,8'd62,8'd63,8'd64,8'd65,8'd67,8'd68,8'd69,8'd70,8'd71,8'd73,8'd74,8'd75,8'd76,
        8'd77,8'd79,
        8'd80,8'd81,8'd82,8'd83,8'd85,8'd86,8'd87,8'd88,8'd89,8'd91,8'd92,8'd93,8'd94,8'd95,8'd96,
        8'd98,8'd99,8'd100,8'd101,8'd102,8'd103,8'd104,8'd106,8'd107,8'd108,8'd109,8'd110,8'd111,
        8'd112,8'd114,8'd115,8'd116,
        8'd117,8'd118,8'd119,8'd120,8'd121,8'd122,8'd124,8'd125,8'd126,8'd127,8'd128,8'd129,8'd130,
        8'd131,8'd132,8'd133,8'd134,8'd135,8'd137,8'd138,8'd139,8'd140,8'd141,8'd142,8'd143,8'd144,
        8'd145,8'd146,8'd147,8'd148,8'd149,8'd150,
        8'd151,8'd152,8'd153,8'd154,8'd155,8'd156,8'd157,8'd158,8'd159,8'd160,8'd161,8'd162,8'd163,
        8'd164,8'd165,8'd166,8'd167,8'd168,8'd169,8'd170,8'd171,8'd172,8'd173,8'd174,8'd175,8'd176,
        8'd177,8'd177,8'd178,8'd179,8'd180,8'd181,
        8'd182,8'd183,8'd184,8'd185,8'd186,8'd187,8'd188,8'd188,8'd189,8'd190,8'd191,8'd192,8'd193,
        8'd194,8'd195,8'd195,8'd196,8'd197,8'd198,8'd199,8'd200,8'd201,8'd201,8'd202,8'd203,8'd204,
        8'd205,8'd206,8'd206,8'd207,8'd208,8'd209,
        8'd210,8'd211,8'd211,8'd212,8'd213,8'd214,8'd215,8'd215,8'd216,8'd217,8'd218,8'd219,8'd219,
        8'd220,8'd221,8'd222,8'd222,8'd223,8'd224,8'd225,8'd225,8'd226,8'd227,8'd228,8'd228,8'd229,
        8'd230,8'd231,8'd231,8'd232,8'd233,8'd234,
        8'd234,8'd235,8'd236,8'd236,8'd237,8'd238,8'd239,8'd239,8'd240,8'd241,8'd241,8'd242,8'd243,
        8'd243,8'd244,8'd245,8'd245,8'd246,8'd247,8'd248,8'd248,8'd249,8'd250,8'd250,8'd251,8'd251,
        8'd252,8'd253,8'd253,8'd254,8'd255,8'd255
    };

    function automatic logic [7:0] atan_lookup(input logic [IDX_W-1:0] idx);
        atan_lookup = ATAN_TAB[idx];
    endfunction

endpackage

// File: hdl/tatan_fold.sv
// Octant fold: swaps and sign changes giving small/large magnitudes and correction word
`timescale 1ns / 1ps

module tatan_fold (
    input  logic signed [15:0]                    y_coord,
    input  logic signed [15:0]                    x_coord,
    output logic [tatan_pkg::MAG_W-1:0]           lo,
    output logic [tatan_pkg::MAG_W-1:0]           hi,
    output logic [tatan_pkg::ANGLE_W-1:0]         corr
);

    logic signed [tatan_pkg::MAG_W-1:0] px;
    logic signed [tatan_pkg::MAG_W-1:0] py;
    logic signed [tatan_pkg::MAG_W-1:0] a;
    logic signed [tatan_pkg::MAG_W-1:0] b;
    logic [tatan_pkg::MAG_W-1:0]        mag_a;
    logic [tatan_pkg::MAG_W-1:0]        mag_b;
    logic [tatan_pkg::ANGLE_W-1:0]      corr_a;
    logic                               px_le0;
    logic                               py_gt0;
    logic                               swap_q;

    always_comb
    begin
        // Widen so that -32768 negates cleanly
        px     = tatan_pkg::MAG_W'(x_coord);
        py     = tatan_pkg::MAG_W'(y_coord);
        px_le0 = px[tatan_pkg::MAG_W-1] || (px == '0);
        py_gt0 = !py[tatan_pkg::MAG_W-1] && (py != '0);
        swap_q = (px_le0 != py_gt0);

        // Quarter-turn swap
        a      = swap_q ? py : px;
        b      = swap_q ? px : py;
        corr_a = swap_q ? tatan_pkg::CORR_QUARTER : '0;

        // Half-turn sign fold on the first coordinate
        if (a[tatan_pkg::MAG_W-1] || (a == '0))
        begin
            mag_a = tatan_pkg::MAG_W'(-a);
        end
        else
        begin
            mag_a  = tatan_pkg::MAG_W'(a);
            corr_a = corr_a ^ tatan_pkg::CORR_HALF;
        end
        mag_b = b[tatan_pkg::MAG_W-1] ? tatan_pkg::MAG_W'(-b) : tatan_pkg::MAG_W'(b);

        // Octant mirror so that lo <= hi
        if (mag_a > mag_b)
        begin
            lo   = mag_b;
            hi   = mag_a;
            corr = corr_a ^ tatan_pkg::CORR_MIRROR;
        end
        else
        begin
            lo   = mag_a;
            hi   = mag_b;
            corr = corr_a;
        end
    end

endmodule

// File: hdl/tatan_unit.sv
// Shared shift / subtract unit: normalising shift and restoring divide steps
`timescale 1ns / 1ps

module tatan_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tatan_pkg::unit_op_t               op,
    input  logic [tatan_pkg::MAG_W-1:0]       load_lo,
    input  logic [tatan_pkg::MAG_W-1:0]       load_hi,
    input  logic [tatan_pkg::ANGLE_W-1:0]     load_corr,
    output tatan_pkg::unit_status_t           status
);

    logic [tatan_pkg::MAG_W-1:0]     lo_reg;
    logic [tatan_pkg::MAG_W-1:0]     lo_next;
    logic [tatan_pkg::MAG_W-1:0]     hi_reg;
    logic [tatan_pkg::MAG_W-1:0]     hi_next;
    logic [tatan_pkg::ANGLE_W-1:0]   corr_reg;
    logic [tatan_pkg::ANGLE_W-1:0]   corr_next;
    logic [tatan_pkg::REM_W-1:0]     rem_reg;
    logic [tatan_pkg::REM_W-1:0]     rem_next;
    logic [tatan_pkg::IDX_W-1:0]     quot_reg;
    logic [tatan_pkg::IDX_W-1:0]     quot_next;
    logic [tatan_pkg::IDX_W-1:0]     rem_sh;
    logic [tatan_pkg::IDX_W-1:0]     divisor;
    logic [tatan_pkg::IDX_W-1:0]     diff;
    logic                            ge;

    // One trial subtract per step
    always_comb
    begin
        rem_sh  = {rem_reg, 1'b0};
        divisor = {1'b0, hi_reg[tatan_pkg::REM_W-1:0]};
        diff    = rem_sh - divisor;
        ge      = (rem_sh >= divisor);
    end

    // Operation select
    always_comb
    begin
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        corr_next = corr_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        case (op)
            tatan_pkg::OP_LOAD:
            begin
                lo_next   = load_lo;
                hi_next   = load_hi;
                corr_next = load_corr;
            end
            tatan_pkg::OP_SHIFT:
            begin
                lo_next = lo_reg >> 1;
                hi_next = hi_reg >> 1;
            end
            tatan_pkg::OP_DIV_INIT:
            begin
                rem_next  = lo_reg[tatan_pkg::REM_W-1:0];
                quot_next = '0;
            end
            tatan_pkg::OP_DIV_STEP:
            begin
                rem_next  = ge ? diff[tatan_pkg::REM_W-1:0] : rem_sh[tatan_pkg::REM_W-1:0];
                quot_next = {quot_reg[tatan_pkg::IDX_W-2:0], ge};
            end
            default:
            begin
            end
        endcase
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        corr_reg <= corr_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    // Status back to the sequencer
    always_comb
    begin
        status.normed   = ((lo_reg | hi_reg) >> tatan_pkg::REM_W) == '0;
        status.hi_zero  = (hi_reg == '0);
        status.lo_eq_hi = (lo_reg == hi_reg);
        status.quot     = quot_reg;
        status.corr     = corr_reg;
    end

    // Normalising shifts never run past zero on a nonzero magnitude
    property p_shift_only_when_large;
        @(posedge clk) disable iff (!rst_n)
        (op == tatan_pkg::OP_SHIFT) |-> !status.normed;
    endproperty
    a_shift_only_when_large: assert property (p_shift_only_when_large)
        else $error("shift issued on already normalised magnitudes");

    // Remainder stays below the divisor across divide steps (equal magnitudes excluded)
    property p_rem_below_divisor;
        @(posedge clk) disable iff (!rst_n)
        ($past(op) == tatan_pkg::OP_DIV_STEP && status.normed && !status.hi_zero &&
         !status.lo_eq_hi)
            |-> ({1'b0, rem_reg} < divisor);
    endproperty
    a_rem_below_divisor: assert property (p_rem_below_divisor)
        else $error("divide remainder not below divisor");

endmodule

// File: hdl/table_atan2_binary_angle_core.sv
// Top level: sequencer, table lookup and result register of the atan2 core
`timescale 1ns / 1ps
// Each item takes k = 0..9 normalising shifts, k being the number needed to bring
// both magnitudes below 128, then 8 restoring divide steps for the ratio.
// A new start is taken only in idle, not while an item is busy; the shared shift / subtract
// unit does one normalising shift or one restoring divide step per cycle.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and clears done.
// The result is shown for one cycle under done and cannot be held off.

module table_atan2_binary_angle_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [15:0]                   y_coord,
    input  logic signed [15:0]                   x_coord,
    output logic                                 done,
    output logic [tatan_pkg::ANGLE_W-1:0]        angle
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;
    logic [tatan_pkg::STEP_W-1:0]      step_reg;
    logic [tatan_pkg::STEP_W-1:0]      step_next;
    logic                              done_reg;
    logic                              done_next;
    logic [tatan_pkg::ANGLE_W-1:0]     angle_reg;
    logic [tatan_pkg::ANGLE_W-1:0]     angle_next;
    tatan_pkg::unit_op_t               op;
    tatan_pkg::unit_status_t           status;
    logic [tatan_pkg::MAG_W-1:0]       fold_lo;
    logic [tatan_pkg::MAG_W-1:0]       fold_hi;
    logic [tatan_pkg::ANGLE_W-1:0]     fold_corr;
    logic [tatan_pkg::ANGLE_W-1:0]     part;

    tatan_fold u_fold (
        .y_coord (y_coord),
        .x_coord (x_coord),
        .lo      (fold_lo),
        .hi      (fold_hi),
        .corr    (fold_corr)
    );

    tatan_unit u_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .load_lo   (fold_lo),
        .load_hi   (fold_hi),
        .load_corr (fold_corr),
        .status    (status)
    );

    // Table part of the angle
    always_comb
    begin
        if (status.hi_zero)
        begin
            part = '0;
        end
        else if (status.lo_eq_hi)
        begin
            part = tatan_pkg::PART_DIAG;
        end
        else
        begin
            part = tatan_pkg::ANGLE_W'(tatan_pkg::atan_lookup(status.quot))
                   << tatan_pkg::PART_SHIFT;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        angle_next = angle_reg;
        op         = tatan_pkg::OP_HOLD;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op         = tatan_pkg::OP_LOAD;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (status.normed)
                begin
                    op         = tatan_pkg::OP_DIV_INIT;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    op = tatan_pkg::OP_SHIFT;
                end
            end
            ST_DIV:
            begin
                op        = tatan_pkg::OP_DIV_STEP;
                step_next = step_reg + 1'b1;
                if (step_reg == tatan_pkg::STEP_W'(tatan_pkg::DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                angle_next = part ^ status.corr;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

    assign busy  = (state_reg != ST_IDLE);
    assign done  = done_reg;
    assign angle = angle_reg;

    // A done beat only follows the final state
    property p_done_after_fin;
        @(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_FIN);
    endproperty
    a_done_after_fin: assert property (p_done_after_fin)
        else $error("done without a finished item");

    // An accepted start makes the core busy next cycle
    property p_start_busy;
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy;
    endproperty
    a_start_busy: assert property (p_start_busy)
        else $error("start accepted but core not busy");

    // Division only runs on normalised magnitudes
    property p_div_normalised;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> status.normed;
    endproperty
    a_div_normalised: assert property (p_div_normalised)
        else $error("divide running on unnormalised magnitudes");

endmodule
